// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the console input escape router modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cier_pkg.sv
// Types and constants shared by the console input escape router modules.
package cier_pkg;

    localparam int CLIENT_SLOTS_DEF = 24;
    localparam int MASK_W           = 24;
    localparam int CLIENT_W         = 5;
    localparam int COUNT_W          = 5;
    localparam int DEBUG_W          = 2;
    localparam int BYTE_W           = 8;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int S_TDATA_W        = 8;
    localparam int M_TDATA_W        = 40;

    localparam logic [BYTE_W-1:0] ESC_BYTE    = 8'h40;
    localparam logic [BYTE_W-1:0] CTRL_C_BYTE = 8'h03;
    localparam logic [BYTE_W-1:0] CTRL_Z_BYTE = 8'h1A;
    localparam logic [BYTE_W-1:0] CR_BYTE     = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE     = 8'h0A;
    localparam logic [BYTE_W-1:0] CMD_MULTI   = 8'h6D;
    localparam logic [BYTE_W-1:0] CMD_MULTI_UP = 8'h4D;
    localparam logic [BYTE_W-1:0] CMD_DEBUG   = 8'h64;
    localparam logic [BYTE_W-1:0] CMD_SCHED   = 8'h73;
    localparam logic [BYTE_W-1:0] CMD_HELP    = 8'h3F;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO  = 8'h30;

    localparam logic [DEBUG_W-1:0] DEBUG_MAX  = 2'd2;

    // Register index of client_count, taken from paddr bit 2.
    localparam logic REG_CLIENT_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_MID     = 2'd0,
        ST_LINE    = 2'd1,
        ST_ESC     = 2'd2,
        ST_COLLECT = 2'd3
    } parse_state_t;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_MULTI_BEGIN = 4'd1,
        EV_ADDED       = 4'd2,
        EV_CONFIRM     = 4'd3,
        EV_SWITCH      = 4'd4,
        EV_INVALID     = 4'd5,
        EV_HELP        = 4'd6,
        EV_DEBUG       = 4'd7,
        EV_SCHED       = 4'd8
    } event_t;

    typedef struct packed {
        logic                deliver;
        logic [MASK_W-1:0]   target_mask;
        event_t              event_res;
        logic [CLIENT_W-1:0] event_client;
        logic [DEBUG_W-1:0]  debug_level;
    } result_t;

endpackage

// File: hw/rtl/cier_cfg_regs.sv
// APB configuration register block holding the client count.
module cier_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cier_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cier_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cier_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [cier_pkg::COUNT_W-1:0]     client_count
);
    import cier_pkg::*;

    logic [COUNT_W-1:0] client_count_reg;
    logic [COUNT_W-1:0] client_count_next;
    logic               sel_count;

    assign pready    = 1'b1;
    assign sel_count = (paddr[2] == REG_CLIENT_COUNT);

    always_comb begin
        client_count_next = client_count_reg;
        if (psel && penable && pwrite && pready && sel_count) begin
            client_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            client_count_reg <= '0;
        end else begin
            client_count_reg <= client_count_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_count) begin
            prdata = APB_DATA_W'(client_count_reg);
        end
    end

    assign client_count = client_count_reg;

endmodule

// File: hw/rtl/cier_decoder.sv
// Escape parser state and routing decision for one received byte.
`include "assert_macros.svh"

module cier_decoder #(
    parameter int CLIENT_SLOTS = cier_pkg::CLIENT_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [cier_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [cier_pkg::COUNT_W-1:0]  client_count,
    output cier_pkg::result_t             result
);
    import cier_pkg::*;

    parse_state_t              state_reg, state_next;
    logic [CLIENT_W-1:0]       single_client_reg, single_client_next;
    logic                      multi_mode_reg, multi_mode_next;
    logic [CLIENT_SLOTS-1:0]   multi_set_reg, multi_set_next;
    logic [DEBUG_W-1:0]        debug_reg, debug_next;

    logic [COUNT_W-1:0]        eff_count;
    logic                      line_end;
    logic [BYTE_W-1:0]         digit_diff;
    logic                      is_digit;
    logic [CLIENT_W-1:0]       digit_idx;
    logic [MASK_W-1:0]         present;
    logic [MASK_W-1:0]         route;
    logic                      fwd;
    event_t                    ev;
    logic [CLIENT_W-1:0]       ev_client;

    assign eff_count  = (client_count > COUNT_W'(CLIENT_SLOTS)) ?
                        COUNT_W'(CLIENT_SLOTS) : client_count;
    assign line_end   = (rx_byte == CR_BYTE) || (rx_byte == LF_BYTE) ||
                        (rx_byte == CTRL_C_BYTE) || (rx_byte == CTRL_Z_BYTE);
    assign digit_diff = rx_byte - DIGIT_ZERO;
    assign is_digit   = (rx_byte >= DIGIT_ZERO) &&
                        (digit_diff < BYTE_W'(eff_count));
    assign digit_idx  = digit_diff[CLIENT_W-1:0];

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            present[i] = (COUNT_W'(i) < eff_count);
        end
    end

    always_comb begin
        if (multi_mode_reg) begin
            route = MASK_W'(multi_set_reg) & present;
        end else begin
            route = (MASK_W'(1) << single_client_reg) & present;
        end
    end

    always_comb begin
        state_next         = state_reg;
        single_client_next = single_client_reg;
        multi_mode_next    = multi_mode_reg;
        multi_set_next     = multi_set_reg;
        debug_next         = debug_reg;
        fwd                = 1'b0;
        ev                 = EV_NONE;
        ev_client          = '0;
        if (eff_count != '0) begin
            case (state_reg)
                ST_MID: begin
                    if (line_end) begin
                        state_next = ST_LINE;
                    end
                    fwd = 1'b1;
                end
                ST_LINE: begin
                    if (line_end) begin
                        fwd = 1'b1;
                    end else if (rx_byte == ESC_BYTE) begin
                        state_next = ST_ESC;
                    end else begin
                        state_next = ST_MID;
                        fwd        = 1'b1;
                    end
                end
                ST_ESC: begin
                    if (rx_byte == ESC_BYTE) begin
                        state_next = ST_MID;
                        fwd        = 1'b1;
                    end else if (rx_byte == CMD_MULTI) begin
                        state_next      = ST_COLLECT;
                        multi_set_next  = '0;
                        multi_mode_next = 1'b1;
                        ev              = EV_MULTI_BEGIN;
                    end else if (rx_byte == CMD_DEBUG) begin
                        debug_next = (debug_reg >= DEBUG_MAX) ? '0 : debug_reg + 1'b1;
                        state_next = ST_LINE;
                        ev         = EV_DEBUG;
                    end else if (rx_byte == CMD_SCHED) begin
                        state_next = ST_LINE;
                        ev         = EV_SCHED;
                    end else if (rx_byte == CMD_HELP) begin
                        state_next = ST_LINE;
                        ev         = EV_HELP;
                    end else begin
                        state_next = ST_LINE;
                        if (is_digit) begin
                            single_client_next = digit_idx;
                            multi_mode_next    = 1'b0;
                            ev                 = EV_SWITCH;
                            ev_client          = digit_idx;
                        end else begin
                            ev = EV_INVALID;
                        end
                    end
                end
                ST_COLLECT: begin
                    if (is_digit) begin
                        multi_set_next = multi_set_reg | (CLIENT_SLOTS'(1) << digit_idx);
                        ev             = EV_ADDED;
                        ev_client      = digit_idx;
                    end else if ((rx_byte == CMD_MULTI) || (rx_byte == CMD_MULTI_UP) ||
                                 (rx_byte == CR_BYTE) || (rx_byte == LF_BYTE)) begin
                        state_next = ST_LINE;
                        ev         = EV_CONFIRM;
                    end
                end
                default: begin
                    state_next = ST_LINE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_LINE;
            single_client_reg <= '0;
            multi_mode_reg    <= 1'b0;
            multi_set_reg     <= '0;
            debug_reg         <= '0;
        end else if (step) begin
            state_reg         <= state_next;
            single_client_reg <= single_client_next;
            multi_mode_reg    <= multi_mode_next;
            multi_set_reg     <= multi_set_next;
            debug_reg         <= debug_next;
        end
    end

    always_comb begin
        result.target_mask  = fwd ? route : '0;
        result.deliver      = fwd && (route != '0);
        result.event_res    = ev;
        result.event_client = ev_client;
        result.debug_level  = debug_next;
    end

    `ASSERT_ALWAYS(a_debug_range, aclk, aresetn, debug_reg <= DEBUG_MAX, "debug level out of range")
    `ASSERT_NEXT(a_multi_begin, aclk, aresetn, step && (ev == EV_MULTI_BEGIN), (state_reg == ST_COLLECT) && (multi_set_reg == '0) && multi_mode_reg, "multi select did not start cleanly")
    `ASSERT_NEXT(a_no_clients_hold, aclk, aresetn, step && (eff_count == '0), $stable(state_reg) && $stable(multi_set_reg) && $stable(single_client_reg), "state changed with no clients present")

endmodule

// File: hw/rtl/console_input_escape_router.sv
// Top level of the console input escape router: stream ports, APB port and pipeline registers.
// Routes received console bytes to one client or a set of clients and decodes '@' commands
// given at line start. One byte is accepted per clock cycle unless the output is stalled.
// Each byte yields exactly one result. The byte sits in the input register during a
// combinational decode, and the result register captures the result when the output can
// advance. While a result waits on m_axis_tready, the result register holds it. The input
// register then takes at most one more byte, and s_axis_tready stays low until the result
// leaves. The user must write client_count over APB (byte address with paddr[2] clear) only
// while no request is in flight; the block does not enforce it. Zero drops every byte.
`include "assert_macros.svh"

module console_input_escape_router #(
    parameter int CLIENT_SLOTS = cier_pkg::CLIENT_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] rx_byte
    input  logic [cier_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] deliver, [24:1] target_mask, [28:25] event_res, [33:29] event_client,
    // [35:34] debug_level, [39:36] zero
    output logic [cier_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cier_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cier_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cier_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import cier_pkg::*;

    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg, in_byte_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_result_reg, out_result_next;
    logic               advance;
    logic               step;
    logic [COUNT_W-1:0] client_count;
    result_t            result;

    cier_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .client_count (client_count)
    );

    cier_decoder #(
        .CLIENT_SLOTS (CLIENT_SLOTS)
    ) u_decoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .client_count (client_count),
        .result       (result)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_byte_next    = in_byte_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (advance) begin
            out_valid_next  = in_valid_reg;
            out_result_next = result;
        end
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
            in_byte_next  = s_axis_tdata[BYTE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg    <= in_byte_next;
        out_result_reg <= out_result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000,
                            out_result_reg.debug_level,
                            out_result_reg.event_client,
                            out_result_reg.event_res,
                            out_result_reg.target_mask,
                            out_result_reg.deliver};

    `ASSERT_IMPLY(a_deliver_mask, aclk, aresetn, out_valid_reg, out_result_reg.deliver == (out_result_reg.target_mask != '0), "deliver disagrees with target mask")
    `ASSERT_IMPLY(a_client_event, aclk, aresetn, out_valid_reg && (out_result_reg.event_client != '0), (out_result_reg.event_res == EV_ADDED) || (out_result_reg.event_res == EV_SWITCH), "client index on an event that names none")
    `ASSERT_NEXT(a_step_result, aclk, aresetn, step, out_valid_reg, "decoded request was not registered")

endmodule
